@@ design/rtlw_pkg.sv @@
// Shared types, constants and helpers for the regression tree leaf walk block.
package rtlw_pkg;

   localparam int NODES    = 1024;
   localparam int FEATURES = 64;
   localparam int CATSETS  = 256;
   localparam int CATS     = 32;

   localparam int MASK_W   = 32;
   localparam int NODE_AW  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int FEAT_AW  = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int CAT_AW   = (CATSETS > 1) ? $clog2(CATSETS) : 1;
   localparam int MOVES_W  = $clog2(NODES + 1);

   typedef enum logic [1:0] {
      CMD_LOAD_NODE = 2'd0,
      CMD_LOAD_CAT  = 2'd1,
      CMD_LOAD_FEAT = 2'd2,
      CMD_CLASSIFY  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_LEAF      = 2'd0,
      ST_UNMATCHED = 2'd1,
      ST_LIMIT     = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  split_var;
      logic [31:0] threshold;
      logic [9:0]  left_child;
      logic [9:0]  right_child;
   } node_type;

   typedef struct packed {
      logic [MASK_W-1:0] left_mask;
      logic [MASK_W-1:0] right_mask;
   } cat_type;

   typedef struct packed {
      logic        node_we;
      logic        cat_we;
      logic        feat_we;
      logic [9:0]  index;
      node_type    node;
      cat_type     cat;
      logic [31:0] feature;
   } load_type;

   typedef struct packed {
      logic               node_re;
      logic [NODE_AW-1:0] node_addr;
      logic               feat_re;
      logic [FEAT_AW-1:0] feat_addr;
      logic               cat_re;
      logic [CAT_AW-1:0]  cat_addr;
   } rd_req_type;

   typedef struct packed {
      node_type    node;
      logic [31:0] feature;
      cat_type     cat;
   } rd_data_type;

   typedef struct packed {
      logic       idle;
      logic       valid;
      logic [9:0] node;
      status_type status;
   } walk_out_type;

   // Integer part of a Q16.16 value, truncated toward zero.
   function automatic logic signed [16:0] int_part(logic signed [31:0] q);
      logic signed [32:0] t;
      t = {q[31], q};
      if (q[31]) begin
         t = t + 33'sd65535;
      end
      return $signed(t[32:16]);
   endfunction

endpackage

@@ design/rtlw_store.sv @@
// Node, category set and feature memories with registered read ports.
module rtlw_store (
   input  logic                 clock,
   input  rtlw_pkg::load_type   load,
   input  rtlw_pkg::rd_req_type rd_req,
   output rtlw_pkg::rd_data_type rd_data
);
   import rtlw_pkg::*;

   node_type          node_mem [NODES];
   cat_type           cat_mem  [CATSETS];
   logic [31:0]       feat_mem [FEATURES];

   node_type          node_rd_ff;
   cat_type           cat_rd_ff;
   logic [31:0]       feat_rd_ff;

   always_ff @(posedge clock) begin
      if (load.node_we && (32'(load.index) < NODES)) begin
         node_mem[NODE_AW'(load.index)] <= load.node;
      end
      if (load.cat_we && (32'(load.index) < CATSETS)) begin
         cat_mem[CAT_AW'(load.index)] <= load.cat;
      end
      if (load.feat_we && (32'(load.index) < FEATURES)) begin
         feat_mem[FEAT_AW'(load.index)] <= load.feature;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req.node_re) begin
         node_rd_ff <= node_mem[rd_req.node_addr];
      end
      if (rd_req.cat_re) begin
         cat_rd_ff <= cat_mem[rd_req.cat_addr];
      end
      if (rd_req.feat_re) begin
         feat_rd_ff <= feat_mem[rd_req.feat_addr];
      end
   end

   assign rd_data.node    = node_rd_ff;
   assign rd_data.cat     = cat_rd_ff;
   assign rd_data.feature = feat_rd_ff;

endmodule

@@ design/rtlw_walker.sv @@
// Tree walk sequencer: one node read, then feature and set reads, then a decision.
module rtlw_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_free,
   output rtlw_pkg::rd_req_type  rd_req,
   input  rtlw_pkg::rd_data_type rd_data,
   output rtlw_pkg::walk_out_type walk_out
);
   import rtlw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NODE_RD,
      S_FEAT,
      S_DECIDE,
      S_DONE
   } state_type;

   state_type          state_ff;
   logic [9:0]         cur_ff;
   logic [MOVES_W-1:0] moves_ff;
   status_type         res_status_ff;
   logic               feat_ok_ff;
   logic               set_ok_ff;

   logic signed [7:0]  k;
   logic [6:0]         fidx;
   logic signed [31:0] thr;
   logic signed [16:0] set_num;
   logic signed [16:0] set_idx;
   logic               feat_ok;
   logic               set_ok;
   logic signed [31:0] x;
   logic signed [16:0] cat;
   logic               cat_ok;
   logic [MASK_W-1:0]  lm;
   logic [MASK_W-1:0]  rm;
   logic               in_l;
   logic               in_r;
   logic               is_cat;
   logic [9:0]         next_node;

   always_comb begin
      k       = $signed(rd_data.node.split_var);
      is_cat  = k[7];
      fidx    = is_cat ? ~k[6:0] : 7'(k - 8'sd1);
      thr     = $signed(rd_data.node.threshold);
      set_num = int_part(thr);
      set_idx = set_num - 17'sd1;
      feat_ok = 32'(fidx) < FEATURES;
      set_ok  = (set_num >= 17'sd1) && (int'(set_num) <= CATSETS);

      x       = feat_ok_ff ? $signed(rd_data.feature) : 32'sd0;
      cat     = int_part(x);
      cat_ok  = (cat >= 17'sd0) && (int'(cat) < CATS) && (int'(cat) < MASK_W);
      lm      = set_ok_ff ? rd_data.cat.left_mask : '0;
      rm      = set_ok_ff ? rd_data.cat.right_mask : '0;
      in_l    = cat_ok && lm[cat[4:0]];
      in_r    = cat_ok && rm[cat[4:0]];
      if (is_cat) begin
         next_node = in_l ? rd_data.node.left_child : rd_data.node.right_child;
      end else begin
         next_node = (x < thr) ? rd_data.node.left_child : rd_data.node.right_child;
      end
   end

   always_comb begin
      rd_req = '0;
      case (state_ff)
         S_NODE_RD: begin
            rd_req.node_re   = 1'b1;
            rd_req.node_addr = NODE_AW'(cur_ff);
         end
         S_FEAT: begin
            rd_req.feat_re   = feat_ok;
            rd_req.feat_addr = FEAT_AW'(fidx);
            rd_req.cat_re    = set_ok && is_cat;
            rd_req.cat_addr  = CAT_AW'(set_idx);
         end
         default: begin
            rd_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_ff        <= '0;
         moves_ff      <= '0;
         res_status_ff <= ST_LEAF;
         feat_ok_ff    <= 1'b0;
         set_ok_ff     <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cur_ff   <= '0;
                  moves_ff <= '0;
                  state_ff <= S_NODE_RD;
               end
            end
            S_NODE_RD: begin
               if (32'(cur_ff) >= NODES) begin
                  res_status_ff <= ST_LEAF;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_FEAT;
               end
            end
            S_FEAT: begin
               if (k == 8'sd0) begin
                  res_status_ff <= ST_LEAF;
                  state_ff      <= S_DONE;
               end else begin
                  feat_ok_ff <= feat_ok;
                  set_ok_ff  <= set_ok && is_cat;
                  state_ff   <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (is_cat && !in_l && !in_r) begin
                  res_status_ff <= ST_UNMATCHED;
                  state_ff      <= S_DONE;
               end else if (32'(moves_ff) >= NODES) begin
                  res_status_ff <= ST_LIMIT;
                  state_ff      <= S_DONE;
               end else begin
                  cur_ff   <= next_node;
                  moves_ff <= MOVES_W'(moves_ff + 1'b1);
                  state_ff <= S_NODE_RD;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign walk_out.idle   = (state_ff == S_IDLE);
   assign walk_out.valid  = (state_ff == S_DONE);
   assign walk_out.node   = cur_ff;
   assign walk_out.status = res_status_ff;

   a_moves_bound: assert property (@(posedge clock) disable iff (reset)
      32'(moves_ff) <= NODES)
      else $error("walk move count beyond node count");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("classify started while a walk is active");

   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_free) |=> (state_ff == S_DONE) && $stable(cur_ff))
      else $error("finished walk result dropped before output was free");

   a_limit_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == ST_LIMIT) |-> (32'(moves_ff) == NODES))
      else $error("walk limit flagged before all moves were taken");

endmodule

@@ design/regression_tree_leaf_walk_top.sv @@
// Top level of the regression tree leaf walk block: stream ports and result register.
//
//   channel | direction | carries
//   req_*   | in        | load node, load category set, load feature, classify row
//   rsp_*   | out       | reached node and status, one item per classify
//
// A load item writes its memory directly when it is accepted.
// A classify item steps through node read, feature and set reads, and decision for each move.
// A walk ends at a leaf, on an unmatched category or at the walk limit.
// Reset clears only control state; the memories are undefined until loaded.
// req_tready is high only while the walker is idle; it rises together with rsp_tvalid, and
// a finished walk that finds the result register still full holds it low until rsp_tready.
module regression_tree_leaf_walk_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // index, split_var, threshold, left_child, right_child, feature_value,
   // left_mask, right_mask; two zero bits on top
   input  logic [167:0] req_tdata,
   // command
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // reached_node; six zero bits on top
   output logic [15:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser
);
   import rtlw_pkg::*;

   load_type     load;
   rd_req_type   rd_req;
   rd_data_type  rd_data;
   walk_out_type walk_out;
   logic         accept;
   logic         start;
   logic         out_free;
   command_type  cmd;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic [9:0]   rsp_node_ff;
   status_type   rsp_status_ff;

   assign req_tready = walk_out.idle;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = command_type'(req_tuser);
   assign start      = accept && (cmd == CMD_CLASSIFY);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      load.node_we               = accept && (cmd == CMD_LOAD_NODE);
      load.cat_we                = accept && (cmd == CMD_LOAD_CAT);
      load.feat_we               = accept && (cmd == CMD_LOAD_FEAT);
      load.index                 = req_tdata[9:0];
      load.node.split_var        = req_tdata[17:10];
      load.node.threshold        = req_tdata[49:18];
      load.node.left_child       = req_tdata[59:50];
      load.node.right_child      = req_tdata[69:60];
      load.feature               = req_tdata[101:70];
      load.cat.left_mask         = req_tdata[133:102];
      load.cat.right_mask        = req_tdata[165:134];
   end

   rtlw_store u_store (
      .clock   (clock),
      .load    (load),
      .rd_req  (rd_req),
      .rd_data (rd_data)
   );

   rtlw_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .rd_req   (rd_req),
      .rd_data  (rd_data),
      .walk_out (walk_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (walk_out.valid && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (walk_out.valid && out_free) begin
         rsp_node_ff   <= walk_out.node;
         rsp_status_ff <= walk_out.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_node_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
